// ===== hw/rtl/dtt_pkg.sv =====
package dtt_pkg;

   // Table geometry.
   localparam int TableDepth = 16;
   localparam int MaxResults = 16;
   localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int CntW       = $clog2(TableDepth + 1);
   localparam int NumW       = $clog2(MaxResults + 1);

   // Command queue between the front and the back.
   localparam int QueueDepth = 4;
   localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW      = $clog2(QueueDepth + 1);

   // Field widths.
   localparam int OpW    = 2;
   localparam int KindW  = 2;
   localparam int OwnerW = 8;
   localparam int IdW    = 16;
   localparam int TimeW  = 56;

   typedef enum logic [OpW-1:0] {
      OP_SCHEDULE = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_EXPIRE   = 2'd2
   } op_type;

   typedef enum logic [KindW-1:0] {
      KIND_EXPIRED = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_FULL    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   // A classified command. The stamp is the deadline for schedule and the
   // current time for expire.
   typedef struct packed {
      op_type              op;
      logic [OwnerW-1:0]   owner;
      logic [IdW-1:0]      timer_id;
      logic [TimeW-1:0]    stamp;
   } cmd_type;

   typedef struct packed {
      logic [OwnerW-1:0]   owner;
      logic [IdW-1:0]      timer_id;
      logic [TimeW-1:0]    deadline;
   } entry_type;

   // Queue handshake between front/back and the command queue.
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_RESP
   } back_state_type;

endpackage

// ===== hw/rtl/dtt_if.sv =====
interface dtt_req_if;
   logic                         valid;
   logic                         ready;
   logic [dtt_pkg::OpW-1:0]      operation;
   logic [dtt_pkg::OwnerW-1:0]   owner;
   logic [dtt_pkg::IdW-1:0]      timer_id;
   logic [dtt_pkg::TimeW-1:0]    deadline;
   logic [dtt_pkg::TimeW-1:0]    current_time;

   modport source (
      output valid, operation, owner, timer_id, deadline, current_time,
      input  ready
   );
   modport sink (
      input  valid, operation, owner, timer_id, deadline, current_time,
      output ready
   );
endinterface

interface dtt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dtt_pkg::KindW-1:0]    kind;
   logic [dtt_pkg::OwnerW-1:0]   owner_res;
   logic [dtt_pkg::IdW-1:0]      timer_id_res;
   logic [dtt_pkg::TimeW-1:0]    deadline_res;
   logic                         last;

   modport source (
      output valid, kind, owner_res, timer_id_res, deadline_res, last,
      input  ready
   );
   modport sink (
      input  valid, kind, owner_res, timer_id_res, deadline_res, last,
      output ready
   );
endinterface

// ===== hw/rtl/deadline_timer_table_unit.sv =====
// Schedule and cancel give their result after a scan over the valid slots (N entries).
// Each entry removed by cancel adds a read and a write of the last slot plus a rescan from the freed slot.
// Expire rescans the whole table for every entry that it emits.
// The back runs one command at a time; while it scans, the entry memory reads one slot a cycle.
// Reset is synchronous and active high; it empties the table, the command queue and the
// output register. Table contents need no clearing pass.
module deadline_timer_table_unit (
   input  logic       clock,
   input  logic       reset,
   dtt_req_if.sink    req_chan,
   dtt_rsp_if.source  rsp_chan
);
   import dtt_pkg::*;

   // The front classifies each request transaction and drops the unused operation
   // code. Known commands go into a short queue, so that the front keeps accepting
   // while the back is busy scanning the table.
   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   dtt_front u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   dtt_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // The back owns the timer table and the output register. It runs one command at
   // a time: a pipelined scan over the valid slots, then a write, a slot move or a
   // response. Expire holds each picked entry until the following scan shows
   // whether another one is due, which decides the last flag of the transaction.
   dtt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_cmd    (head_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hw/rtl/dtt_front.sv =====
module dtt_front (
   dtt_req_if.sink                  req_chan,
   input  dtt_pkg::queue_status_type q_status,
   output logic                     q_push,
   output dtt_pkg::cmd_type         q_cmd
);
   import dtt_pkg::*;

   logic accept;
   logic known_op;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // The unused operation code is taken and dropped here.
   assign known_op = (req_chan.operation == OP_SCHEDULE) ||
                     (req_chan.operation == OP_CANCEL)   ||
                     (req_chan.operation == OP_EXPIRE);

   assign q_push = accept && known_op;

   always_comb begin
      q_cmd.op       = op_type'(req_chan.operation);
      q_cmd.owner    = req_chan.owner;
      q_cmd.timer_id = req_chan.timer_id;
      if (req_chan.operation == OP_EXPIRE) begin
         q_cmd.stamp = req_chan.current_time;
      end else begin
         q_cmd.stamp = req_chan.deadline;
      end
   end

endmodule

// ===== hw/rtl/dtt_cmd_queue.sv =====
module dtt_cmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dtt_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output dtt_pkg::cmd_type          head_cmd,
   output dtt_pkg::queue_status_type status
);
   import dtt_pkg::*;

   cmd_type            slot_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (cnt_ff == QCntW'(QueueDepth));
   assign status.valid = (cnt_ff != '0);
   assign head_cmd     = slot_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + QPtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/dtt_back.sv =====
module dtt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dtt_pkg::queue_status_type q_status,
   input  dtt_pkg::cmd_type          q_cmd,
   output logic                      q_pop,
   dtt_rsp_if.source                 rsp_chan
);
   import dtt_pkg::*;

   // Timer table memory, one read and one write port, registered read.
   entry_type          entry_mem [TableDepth];
   entry_type          rd_data_ff;
   logic [IdxW-1:0]    rd_addr;
   logic               mem_we;
   logic [IdxW-1:0]    mem_wa;
   entry_type          mem_wd;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    scan_ptr_ff, scan_ptr_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IdxW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic               found_ff, found_in;
   logic [IdxW-1:0]    best_idx_ff, best_idx_in;
   entry_type          best_ff, best_in;
   logic               pend_vld_ff, pend_vld_in;
   entry_type          pend_ff, pend_in;
   logic [NumW-1:0]    num_ff, num_in;
   logic [IdxW-1:0]    slot_ff, slot_in;
   kind_type           resp_kind_ff, resp_kind_in;

   logic               out_vld_ff, out_vld_in;
   kind_type           out_kind_ff, out_kind_in;
   entry_type          out_entry_ff, out_entry_in;
   logic               out_last_ff, out_last_in;

   logic               issue;
   logic               scan_end;
   logic               key_hit;
   logic               due;
   logic               better;
   logic               out_free;
   logic               table_full;
   logic [CntW-1:0]    last_slot;
   logic               emit;
   kind_type           emit_kind;
   entry_type          emit_entry;
   logic               emit_last;

   assign issue      = (state_ff == ST_SCAN) && (scan_ptr_ff < count_ff);
   assign scan_end   = (state_ff == ST_SCAN) && !issue && !cmp_vld_ff;
   assign key_hit    = cmp_vld_ff && (rd_data_ff.owner == cmd_ff.owner) &&
                       (rd_data_ff.timer_id == cmd_ff.timer_id);
   assign due        = cmp_vld_ff && (rd_data_ff.deadline <= cmd_ff.stamp);
   assign better     = due && (!found_ff || (rd_data_ff.deadline < best_ff.deadline) ||
                       ((rd_data_ff.deadline == best_ff.deadline) &&
                        (rd_data_ff.timer_id < best_ff.timer_id)));
   assign out_free   = !out_vld_ff || rsp_chan.ready;
   assign table_full = (count_ff == CntW'(TableDepth));
   assign last_slot  = count_ff - CntW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            case (cmd_ff.op)
               OP_SCHEDULE: begin
                  if (key_hit || scan_end) begin
                     state_in = ST_RESP;
                  end
               end
               OP_CANCEL: begin
                  if (key_hit) begin
                     state_in = ST_DROP_RD;
                  end else if (scan_end) begin
                     state_in = ST_RESP;
                  end
               end
               OP_EXPIRE: begin
                  if (scan_end) begin
                     state_in = found_ff ? ST_PICK : ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_PICK: begin
            if (!pend_vld_ff || out_free) begin
               state_in = ST_DROP_RD;
            end
         end
         ST_DROP_RD: begin
            state_in = ST_DROP_WR;
         end
         ST_DROP_WR: begin
            if ((cmd_ff.op == OP_EXPIRE) && (num_ff == NumW'(MaxResults))) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      scan_ptr_in  = issue ? scan_ptr_ff + CntW'(1) : scan_ptr_ff;
      cmp_vld_in   = issue;
      cmp_idx_in   = scan_ptr_ff[IdxW-1:0];
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      num_in       = num_ff;
      slot_in      = slot_ff;
      resp_kind_in = resp_kind_ff;
      q_pop        = 1'b0;
      rd_addr      = scan_ptr_ff[IdxW-1:0];
      mem_we       = 1'b0;
      mem_wa       = cmp_idx_ff;
      mem_wd       = rd_data_ff;
      emit         = 1'b0;
      emit_kind    = KIND_DONE;
      emit_entry   = '0;
      emit_last    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               q_pop       = 1'b1;
               cmd_in      = q_cmd;
               scan_ptr_in = '0;
               cmp_vld_in  = 1'b0;
               found_in    = 1'b0;
               pend_vld_in = 1'b0;
               num_in      = '0;
            end
         end
         ST_SCAN: begin
            case (cmd_ff.op)
               OP_SCHEDULE: begin
                  if (key_hit) begin
                     mem_we       = 1'b1;
                     mem_wa       = cmp_idx_ff;
                     mem_wd       = '{owner: cmd_ff.owner, timer_id: cmd_ff.timer_id,
                                      deadline: cmd_ff.stamp};
                     resp_kind_in = KIND_DONE;
                  end else if (scan_end) begin
                     if (table_full) begin
                        resp_kind_in = KIND_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        mem_wa       = count_ff[IdxW-1:0];
                        mem_wd       = '{owner: cmd_ff.owner, timer_id: cmd_ff.timer_id,
                                         deadline: cmd_ff.stamp};
                        count_in     = count_ff + CntW'(1);
                        resp_kind_in = KIND_DONE;
                     end
                  end
               end
               OP_CANCEL: begin
                  if (key_hit) begin
                     slot_in = cmp_idx_ff;
                  end
                  resp_kind_in = KIND_DONE;
               end
               OP_EXPIRE: begin
                  if (better) begin
                     found_in    = 1'b1;
                     best_idx_in = cmp_idx_ff;
                     best_in     = rd_data_ff;
                  end
               end
               default: begin
                  resp_kind_in = KIND_DONE;
               end
            endcase
         end
         ST_PICK: begin
            if (!pend_vld_ff || out_free) begin
               // The previously picked entry is not the last one after all.
               if (pend_vld_ff) begin
                  emit       = 1'b1;
                  emit_kind  = KIND_EXPIRED;
                  emit_entry = pend_ff;
                  emit_last  = 1'b0;
               end
               pend_in     = best_ff;
               pend_vld_in = 1'b1;
               num_in      = num_ff + NumW'(1);
               slot_in     = best_idx_ff;
            end
         end
         ST_DROP_RD: begin
            rd_addr = last_slot[IdxW-1:0];
         end
         ST_DROP_WR: begin
            // The freed slot takes the last entry.
            mem_we     = 1'b1;
            mem_wa     = slot_ff;
            mem_wd     = rd_data_ff;
            count_in   = count_ff - CntW'(1);
            cmp_vld_in = 1'b0;
            found_in   = 1'b0;
            if (cmd_ff.op == OP_CANCEL) begin
               scan_ptr_in = CntW'(slot_ff);
            end else begin
               scan_ptr_in = '0;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               if (cmd_ff.op == OP_EXPIRE) begin
                  if (pend_vld_ff) begin
                     emit_kind  = KIND_EXPIRED;
                     emit_entry = pend_ff;
                  end else begin
                     emit_kind  = KIND_NONE;
                  end
               end else begin
                  emit_kind = resp_kind_ff;
               end
            end
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   // Output register.
   always_comb begin
      out_kind_in  = out_kind_ff;
      out_entry_in = out_entry_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_vld_in   = 1'b1;
         out_kind_in  = emit_kind;
         out_entry_in = emit_entry;
         out_last_in  = emit_last;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.kind         = out_kind_ff;
   assign rsp_chan.owner_res    = out_entry_ff.owner;
   assign rsp_chan.timer_id_res = out_entry_ff.timer_id;
   assign rsp_chan.deadline_res = out_entry_ff.deadline;
   assign rsp_chan.last         = out_last_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         scan_ptr_ff <= '0;
         cmp_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         num_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_ptr_ff <= scan_ptr_in;
         cmp_vld_ff  <= cmp_vld_in;
         found_ff    <= found_in;
         pend_vld_ff <= pend_vld_in;
         num_ff      <= num_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      pend_ff      <= pend_in;
      slot_ff      <= slot_in;
      resp_kind_ff <= resp_kind_in;
      out_kind_ff  <= out_kind_in;
      out_entry_ff <= out_entry_in;
      out_last_ff  <= out_last_in;
   end

endmodule

// ===== tb/deadline_timer_table_unit_test.sv =====
module deadline_timer_table_unit_test;
   import dtt_pkg::*;

   // Operation code 3 has no member in the package enum. The block must drop
   // such a transaction without a response and without touching the table.
   localparam logic [OpW-1:0]   OP_UNUSED   = 2'd3;
   localparam logic [TimeW-1:0] TIME_MAX    = {TimeW{1'b1}};
   localparam int               RandomItems = 190;
   localparam int               PoolSize    = 24;
   // Once fewer items than this are left to send, neither side starts a new idle burst.
   localparam int               CalmTail    = 40;
   localparam int               DrainCycles = 64;
   localparam int               PrintCap    = 50;

   typedef struct packed {
      logic [OpW-1:0]    op;
      logic [OwnerW-1:0] owner;
      logic [IdW-1:0]    timer_id;
      logic [TimeW-1:0]  deadline;
      logic [TimeW-1:0]  current_time;
   } timer_request_type;

   typedef struct packed {
      kind_type          kind;
      logic [OwnerW-1:0] owner;
      logic [IdW-1:0]    timer_id;
      logic [TimeW-1:0]  deadline;
      logic              last;
   } timer_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dtt_req_if req_if ();
   dtt_rsp_if rsp_if ();

   deadline_timer_table_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // Commands waiting to be offered to the block, and the responses that the
   // shadow table says must come back, oldest first.
   timer_request_type pending_cmds[$];
   timer_outcome_type table_outcomes[$];
   timer_request_type in_flight;

   // Shadow copy of the timer table.
   logic [OwnerW-1:0] shadow_owner    [TableDepth];
   logic [IdW-1:0]    shadow_id       [TableDepth];
   logic [TimeW-1:0]  shadow_deadline [TableDepth];
   int                shadow_count = 0;

   int  mismatch_count = 0;
   int  accepted_count = 0;
   int  items_total    = 0;
   int  op_tally[4]    = '{default: 0};
   int  expired_seen   = 0;
   int  full_seen      = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  stretch_cycles = 0;
   logic quiet_stretch = 1'b0;

   task automatic log_mismatch(input string what);
      if (mismatch_count < PrintCap)
         $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string field, input logic [TimeW-1:0] got,
                                input logic [TimeW-1:0] want);
      if (got !== want)
         log_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   function automatic logic [TimeW-1:0] rand_time();
      return TimeW'({$urandom, $urandom});
   endfunction

   function automatic bit winding_down();
      return pending_cmds.size() < CalmTail;
   endfunction

   // A freed slot is refilled with the entry from the end of the table.
   function automatic void vacate_slot(input int slot);
      shadow_count--;
      shadow_owner[slot]    = shadow_owner[shadow_count];
      shadow_id[slot]       = shadow_id[shadow_count];
      shadow_deadline[slot] = shadow_deadline[shadow_count];
   endfunction

   // Apply one accepted command to the shadow table and queue the responses
   // that it must produce.
   task automatic advance_timer_table(input timer_request_type r);
      timer_outcome_type o;
      int                hit;
      int                best;
      int                emitted;
      int                i;

      o = '{kind: KIND_DONE, owner: '0, timer_id: '0, deadline: '0, last: 1'b1};
      case (r.op)
         OP_SCHEDULE: begin
            hit = -1;
            for (i = 0; i < shadow_count; i++)
               if (hit < 0 && shadow_id[i] == r.timer_id && shadow_owner[i] == r.owner)
                  hit = i;
            if (hit >= 0) begin
               shadow_deadline[hit] = r.deadline;
            end else if (shadow_count >= TableDepth) begin
               o.kind = KIND_FULL;
            end else begin
               shadow_owner[shadow_count]    = r.owner;
               shadow_id[shadow_count]       = r.timer_id;
               shadow_deadline[shadow_count] = r.deadline;
               shadow_count++;
            end
            table_outcomes.push_back(o);
         end
         OP_CANCEL: begin
            i = 0;
            while (i < shadow_count) begin
               if (shadow_id[i] == r.timer_id && shadow_owner[i] == r.owner)
                  vacate_slot(i);
               else
                  i++;
            end
            table_outcomes.push_back(o);
         end
         OP_EXPIRE: begin
            emitted = 0;
            while (emitted < MaxResults) begin
               // Earliest deadline wins, then the lower id, then the lower slot.
               best = -1;
               for (i = 0; i < shadow_count; i++)
                  if (shadow_deadline[i] <= r.current_time &&
                      (best < 0 || shadow_deadline[i] < shadow_deadline[best] ||
                       (shadow_deadline[i] == shadow_deadline[best] &&
                        shadow_id[i] < shadow_id[best])))
                     best = i;
               if (best < 0)
                  break;
               o.kind     = KIND_EXPIRED;
               o.owner    = shadow_owner[best];
               o.timer_id = shadow_id[best];
               o.deadline = shadow_deadline[best];
               o.last     = 1'b0;
               table_outcomes.push_back(o);
               emitted++;
               vacate_slot(best);
            end
            if (emitted == 0) begin
               o.kind = KIND_NONE;
               table_outcomes.push_back(o);
            end else begin
               // Only the final expired entry of the burst carries the last flag.
               o = table_outcomes.pop_back();
               o.last = 1'b1;
               table_outcomes.push_back(o);
            end
         end
         OP_UNUSED: ;
         default: ;
      endcase
   endtask

   task automatic add_cmd(input logic [OpW-1:0] op, input logic [OwnerW-1:0] owner,
                          input logic [IdW-1:0] timer_id, input logic [TimeW-1:0] deadline,
                          input logic [TimeW-1:0] current_time);
      timer_request_type r;

      r.op           = op;
      r.owner        = owner;
      r.timer_id     = timer_id;
      r.deadline     = deadline;
      r.current_time = current_time;
      pending_cmds.push_back(r);
      op_tally[op]++;
      items_total++;
   endtask

   // Idle and stall bursts are allowed only outside quiet stretches, which are
   // re-rolled at the end of each stretch so that long runs at full rate also occur.
   always @(posedge clock) begin
      stretch_cycles <= stretch_cycles + 1;
      if (stretch_cycles % 128 == 127)
         quiet_stretch <= ($urandom_range(0, 3) == 0);
   end

   // Request driver. A transaction completes when valid and ready are both high
   // at a rising edge; the accepted command is then applied to the shadow table.
   // The next command is loaded only after the current one is accepted or while
   // valid is low, so valid never drops while a command is on offer.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.operation    <= '0;
         req_if.owner        <= '0;
         req_if.timer_id     <= '0;
         req_if.deadline     <= '0;
         req_if.current_time <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_timer_table(in_flight);
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (!winding_down() && !quiet_stretch && $urandom_range(0, 7) == 0) begin
               // Start an idle burst, of which the current cycle is the first.
               gap_left = $urandom_range(1, 16) - 1;
               req_if.valid <= 1'b0;
            end else begin
               in_flight = pending_cmds.pop_front();
               req_if.valid        <= 1'b1;
               req_if.operation    <= in_flight.op;
               req_if.owner        <= in_flight.owner;
               req_if.timer_id     <= in_flight.timer_id;
               req_if.deadline     <= in_flight.deadline;
               req_if.current_time <= in_flight.current_time;
            end
         end
      end
   end

   // Response monitor. Every completed response transaction is compared field
   // by field with the oldest outstanding prediction. Ready is withdrawn in
   // random bursts to exercise back-pressure at random points of a burst.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (table_outcomes.size() == 0) begin
               log_mismatch($sformatf("response kind %0d arrived with nothing outstanding",
                                      rsp_if.kind));
            end else begin
               compare_field("kind", TimeW'(rsp_if.kind), TimeW'(table_outcomes[0].kind));
               compare_field("owner", TimeW'(rsp_if.owner_res),
                             TimeW'(table_outcomes[0].owner));
               compare_field("timer id", TimeW'(rsp_if.timer_id_res),
                             TimeW'(table_outcomes[0].timer_id));
               compare_field("deadline", rsp_if.deadline_res, table_outcomes[0].deadline);
               compare_field("last", TimeW'(rsp_if.last), TimeW'(table_outcomes[0].last));
               if (table_outcomes[0].kind == KIND_EXPIRED)
                  expired_seen++;
               if (table_outcomes[0].kind == KIND_FULL)
                  full_seen++;
               void'(table_outcomes.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!winding_down() && !quiet_stretch && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [OwnerW-1:0] pool_owner [PoolSize];
      logic [IdW-1:0]    pool_id    [PoolSize];
      logic [TimeW-1:0]  time_base;
      logic [TimeW-1:0]  due_at;
      logic [TimeW-1:0]  last_deadline;
      logic [OpW-1:0]    noise_op;
      int                random_count;
      int                pick;
      int                slot;

      // Directed part. Expire and cancel on an empty table, then the unused code.
      add_cmd(OP_EXPIRE, 8'h00, 16'h0000, '0, '0);
      add_cmd(OP_CANCEL, 8'hA5, 16'h1234, '0, '0);
      add_cmd(OP_UNUSED, 8'hFF, 16'hFFFF, TIME_MAX, TIME_MAX);

      // Fill the table. The first entry has the smallest fields, the last one the
      // largest. In between, groups share a deadline: some differ only in owner,
      // so they tie on id too and leave by slot, others differ in id.
      for (int k = 0; k < TableDepth; k++) begin
         if (k == 0)
            add_cmd(OP_SCHEDULE, 8'h00, 16'h0000, '0, rand_time());
         else if (k == TableDepth - 1)
            add_cmd(OP_SCHEDULE, 8'hFF, 16'hFFFF, TIME_MAX, rand_time());
         else
            add_cmd(OP_SCHEDULE, OwnerW'(k % 4), IdW'(k / 4),
                    (k < 4) ? 56'd5000 : (k < 12) ? 56'd1000 : 56'd3000, rand_time());
      end

      // A new key on a full table is refused, while a known key is still updated.
      add_cmd(OP_SCHEDULE, 8'h5A, 16'hBEEF, 56'd42, '0);
      add_cmd(OP_SCHEDULE, 8'h02, 16'h0001, 56'd7, '0);
      // Cancel frees a slot in the middle, which the last entry fills; the new key goes at the end.
      add_cmd(OP_CANCEL, 8'h01, 16'h0002, rand_time(), rand_time());
      add_cmd(OP_SCHEDULE, 8'h80, 16'h8000, 56'd1000, '0);
      // Everything is due at the largest time, a deadline equal to it included,
      // so the whole table drains in one burst; a second expire finds nothing.
      add_cmd(OP_EXPIRE, 8'h00, 16'h0000, '0, TIME_MAX);
      add_cmd(OP_EXPIRE, 8'h00, 16'h0000, '0, TIME_MAX);

      // Random part. A small pool of keys makes updates, cancels of live
      // entries and a full table common. Two keys share an id.
      for (int k = 0; k < PoolSize; k++) begin
         pool_owner[k] = OwnerW'($urandom_range(0, 255));
         pool_id[k]    = IdW'($urandom_range(0, 65535));
      end
      pool_id[1]    = pool_id[0];
      time_base     = rand_time() >> 1;
      last_deadline = time_base;
      random_count  = 0;
      while (random_count < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            repeat ($urandom_range(1, 6)) begin
               slot          = $urandom_range(0, PoolSize - 1);
               last_deadline = time_base + $urandom_range(0, 4000);
               add_cmd(OP_SCHEDULE, pool_owner[slot], pool_id[slot], last_deadline,
                       rand_time());
               random_count++;
            end
         end else if (pick < 60) begin
            slot = $urandom_range(0, PoolSize - 1);
            add_cmd(OP_CANCEL, pool_owner[slot], pool_id[slot], rand_time(), rand_time());
            random_count++;
         end else if (pick < 85) begin
            // Now and then the time equals the latest deadline exactly.
            due_at = ($urandom_range(0, 3) == 0) ? last_deadline
                                                 : time_base + $urandom_range(0, 4000);
            add_cmd(OP_EXPIRE, OwnerW'($urandom_range(0, 255)),
                    IdW'($urandom_range(0, 65535)), rand_time(), due_at);
            time_base = time_base + $urandom_range(0, 2500);
            random_count++;
         end else begin
            // Noise: any code with fully random fields.
            noise_op = OpW'($urandom_range(0, 3));
            add_cmd(noise_op, OwnerW'($urandom_range(0, 255)),
                    IdW'($urandom_range(0, 65535)), rand_time(), rand_time());
            if (noise_op != OP_UNUSED)
               random_count++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every command has been taken and every response has come,
      // then watch a little longer for anything spurious.
      wait (accepted_count == items_total);
      wait (table_outcomes.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (table_outcomes.size() != 0)
         log_mismatch($sformatf("%0d responses never arrived", table_outcomes.size()));

      $display("Sent %0d schedule, %0d cancel, %0d expire and %0d unused-code commands.",
               op_tally[OP_SCHEDULE], op_tally[OP_CANCEL], op_tally[OP_EXPIRE],
               op_tally[OP_UNUSED]);
      $display("Checked %0d expired timers and %0d full-table refusals; %0d mismatches.",
               expired_seen, full_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Generous limit: far beyond a run in which every command is a full expire
   // burst with maximal stalls on both sides.
   initial begin
      #8_000_000;
      $display("Timeout with %0d of %0d commands accepted and %0d responses outstanding.",
               accepted_count, items_total, table_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_if.sv
hw/rtl/dtt_front.sv
hw/rtl/dtt_cmd_queue.sv
hw/rtl/dtt_back.sv
hw/rtl/deadline_timer_table_unit.sv
tb/deadline_timer_table_unit_test.sv
